/* src/prbv_pkg.sv */
// Shared types, constants and the magic table of the packed record blob validator.
`default_nettype none

package prbv_pkg;

  // Field and register widths.
  localparam int unsigned VERSION_W = 32;
  localparam int unsigned RECSIZE_W = 16;
  localparam int unsigned GROUPS_W  = 9;
  localparam int unsigned RECORDS_W = 17;
  localparam int unsigned TEXT_W    = 25;
  localparam int unsigned LEFT_W    = 33;
  localparam int unsigned INDEX_W   = 3;
  localparam int unsigned FCOUNT_W  = 5;

  // Byte positions inside the header and the key.
  localparam logic [FCOUNT_W-1:0] MAGIC_LAST   = 5'd7;
  localparam logic [FCOUNT_W-1:0] VERSION_LAST = 5'd11;
  localparam logic [FCOUNT_W-1:0] SIZE_LAST    = 5'd15;
  localparam logic [FCOUNT_W-1:0] GCOUNT_LAST  = 5'd19;
  localparam logic [FCOUNT_W-1:0] HEADER_LAST  = 5'd23;
  localparam logic [FCOUNT_W-1:0] KEY_LAST     = 5'd7;

  // Hard ceiling on the group count.
  localparam logic [GROUPS_W-1:0] GROUP_CEILING = 9'd256;

  // Register reset values.
  localparam logic [VERSION_W-1:0] RST_EXPECTED_VERSION = 32'd1;
  localparam logic [RECSIZE_W-1:0] RST_RECORD_SIZE      = 16'd64;
  localparam logic [GROUPS_W-1:0]  RST_MAX_GROUPS       = 9'd256;
  localparam logic [RECORDS_W-1:0] RST_MAX_RECORDS      = 17'd100000;
  localparam logic [TEXT_W-1:0]    RST_MAX_TEXT_BYTES   = 25'd16777216;

  typedef enum logic [2:0] {
    SEC_HEADER  = 3'd0,
    SEC_KEY     = 3'd1,
    SEC_COUNT   = 3'd2,
    SEC_TEXTLEN = 3'd3,
    SEC_DATA    = 3'd4,
    SEC_TEXT    = 3'd5,
    SEC_TRAIL   = 3'd6
  } sec_t;

  typedef enum logic [3:0] {
    ST_PARSING       = 4'd0,
    ST_ACCEPTED      = 4'd1,
    ST_SHORT_HEADER  = 4'd2,
    ST_MAGIC_VERSION = 4'd3,
    ST_RECORD_SIZE   = 4'd4,
    ST_GROUP_COUNT   = 4'd5,
    ST_TRUNCATED     = 4'd6,
    ST_IMPLAUSIBLE   = 4'd7,
    ST_TRAILING      = 4'd8
  } status_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_EXPECTED_VERSION = 3'd0,
    REG_RECORD_SIZE      = 3'd1,
    REG_MAX_GROUPS       = 3'd2,
    REG_MAX_RECORDS      = 3'd3,
    REG_MAX_TEXT_BYTES   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [VERSION_W-1:0] expected_version;
    logic [RECSIZE_W-1:0] record_size;
    logic [GROUPS_W-1:0]  max_groups;
    logic [RECORDS_W-1:0] max_records;
    logic [TEXT_W-1:0]    max_text_bytes;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] byte_value;
    sec_t       section;
    logic [7:0] group_index;
    status_t    status;
    logic       blob_done;
  } res_t;

  // Expected magic byte at header position k.
  function automatic logic [7:0] magic_byte(input logic [2:0] k);
    logic [7:0] m;
    unique case (k)
      3'd0:    m = 8'h42;
      3'd1:    m = 8'h42;
      3'd2:    m = 8'h43;
      3'd3:    m = 8'h46;
      3'd4:    m = 8'h49;
      3'd5:    m = 8'h4D;
      3'd6:    m = 8'h50;
      default: m = 8'h43;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* src/prbv_in_if.sv */
// Input byte channel: valid/ready with one blob byte and its last-byte flag.
`default_nettype none

interface prbv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

/* src/prbv_out_if.sv */
// Result channel: valid/ready with the tagged byte and its status.
`default_nettype none

interface prbv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [2:0] section;
  logic [7:0] group_index;
  logic [3:0] status;
  logic       blob_done;

  modport source (output valid, output byte_value, output section, output group_index,
                  output status, output blob_done, input ready);
  modport sink   (input valid, input byte_value, input section, input group_index,
                  input status, input blob_done, output ready);
endinterface

`default_nettype wire

/* src/prbv_cfg_if.sv */
// Configuration write channel: valid/ready with register index and write data.
`default_nettype none

interface prbv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/prbv_parser.sv */
// Parse state of the blob and the per-byte step logic that tags each byte.
`default_nettype none

module prbv_parser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          data_byte,
  input  wire logic                final_byte,
  input  wire prbv_pkg::cfg_regs_t regs,
  output prbv_pkg::res_t           res
);
  import prbv_pkg::*;

  // Parse state registers.
  sec_t                 section_state;
  logic [FCOUNT_W-1:0]  field_byte_count;
  logic [23:0]          field_shift;
  logic                 magic_ok;
  logic                 size_ok;
  logic                 count_ok;
  logic                 cnt_plausible;
  logic [GROUPS_W-1:0]  group_total;
  logic [7:0]           group_current;
  logic [RECORDS_W-1:0] record_count;
  logic [TEXT_W-1:0]    text_left;
  logic [LEFT_W-1:0]    bytes_left;
  status_t              error_code;

  sec_t                 section_state_next;
  logic [FCOUNT_W-1:0]  field_byte_count_next;
  logic [23:0]          field_shift_next;
  logic                 magic_ok_next;
  logic                 size_ok_next;
  logic                 count_ok_next;
  logic                 cnt_plausible_next;
  logic [GROUPS_W-1:0]  group_total_next;
  logic [7:0]           group_current_next;
  logic [RECORDS_W-1:0] record_count_next;
  logic [TEXT_W-1:0]    text_left_next;
  logic [LEFT_W-1:0]    bytes_left_next;
  status_t              error_code_next;

  logic [1:0]           pos;
  logic                 word_last;
  logic [31:0]          word;
  logic [23:0]          gathered;
  logic [GROUPS_W-1:0]  limit;
  logic [GROUPS_W-1:0]  group_inc;
  logic                 last_group;
  logic [LEFT_W-1:0]    data_bytes;
  logic                 data_nonzero;
  logic [LEFT_W-1:0]    bytes_dec;
  logic [TEXT_W-1:0]    text_dec;
  sec_t                 out_sec;
  status_t              status;

  // Little-endian word assembly: the full word is ready on its fourth byte.
  assign pos       = field_byte_count[1:0];
  assign word_last = (pos == 2'd3);
  assign word      = {data_byte, field_shift};
  assign gathered  = (pos == 2'd0) ? {16'h0000, data_byte}
                                   : field_shift | ({16'h0000, data_byte} << {pos, 3'b000});

  // Group count ceiling and end-of-group test.
  assign limit      = (regs.max_groups < GROUP_CEILING) ? regs.max_groups : GROUP_CEILING;
  assign group_inc  = {1'b0, group_current} + 9'd1;
  assign last_group = (group_inc >= group_total);

  // Data length of one group; zero exactly when either factor is zero.
  assign data_bytes   = LEFT_W'(record_count) * LEFT_W'(regs.record_size);
  assign data_nonzero = (record_count != '0) && (regs.record_size != '0);

  assign bytes_dec = (bytes_left != '0) ? bytes_left - LEFT_W'(1) : bytes_left;
  assign text_dec  = (text_left != '0) ? text_left - TEXT_W'(1) : text_left;

  // Step logic for one byte.
  always_comb begin
    section_state_next    = section_state;
    field_byte_count_next = field_byte_count;
    field_shift_next      = field_shift;
    magic_ok_next         = magic_ok;
    size_ok_next          = size_ok;
    count_ok_next         = count_ok;
    cnt_plausible_next    = cnt_plausible;
    group_total_next      = group_total;
    group_current_next    = group_current;
    record_count_next     = record_count;
    text_left_next        = text_left;
    bytes_left_next       = bytes_left;
    error_code_next       = error_code;
    out_sec               = section_state;

    unique case (section_state)
      SEC_HEADER: begin
        if (field_byte_count <= MAGIC_LAST) begin
          if (data_byte != magic_byte(field_byte_count[2:0])) begin
            magic_ok_next = 1'b0;
          end
        end else begin
          field_shift_next = gathered;
          if (field_byte_count == VERSION_LAST && word != regs.expected_version) begin
            magic_ok_next = 1'b0;
          end
          if (field_byte_count == SIZE_LAST) begin
            size_ok_next = (word == 32'(regs.record_size));
          end
          if (field_byte_count == GCOUNT_LAST) begin
            count_ok_next    = (word != '0) && (word <= 32'(limit));
            group_total_next = count_ok_next ? word[GROUPS_W-1:0] : '0;
          end
        end
        // Header checks in priority order at the last header byte.
        if (field_byte_count >= HEADER_LAST) begin
          if (!magic_ok_next) begin
            error_code_next    = ST_MAGIC_VERSION;
            section_state_next = SEC_TRAIL;
          end else if (!size_ok_next) begin
            error_code_next    = ST_RECORD_SIZE;
            section_state_next = SEC_TRAIL;
          end else if (!count_ok_next) begin
            error_code_next    = ST_GROUP_COUNT;
            section_state_next = SEC_TRAIL;
          end else begin
            section_state_next    = SEC_KEY;
            field_byte_count_next = '0;
            group_current_next    = '0;
          end
        end else begin
          field_byte_count_next = field_byte_count + FCOUNT_W'(1);
        end
      end
      SEC_KEY: begin
        if (field_byte_count >= KEY_LAST) begin
          section_state_next    = SEC_COUNT;
          field_byte_count_next = '0;
        end else begin
          field_byte_count_next = field_byte_count + FCOUNT_W'(1);
        end
      end
      SEC_COUNT: begin
        field_shift_next = gathered;
        if (word_last) begin
          cnt_plausible_next    = (word <= 32'(regs.max_records));
          record_count_next     = cnt_plausible_next ? word[RECORDS_W-1:0] : '0;
          section_state_next    = SEC_TEXTLEN;
          field_byte_count_next = '0;
        end else begin
          field_byte_count_next = field_byte_count + FCOUNT_W'(1);
        end
      end
      SEC_TEXTLEN: begin
        field_shift_next = gathered;
        if (word_last) begin
          field_byte_count_next = '0;
          if (!cnt_plausible || word > 32'(regs.max_text_bytes)) begin
            error_code_next    = ST_IMPLAUSIBLE;
            section_state_next = SEC_TRAIL;
          end else begin
            text_left_next  = word[TEXT_W-1:0];
            bytes_left_next = data_bytes;
            if (data_nonzero) begin
              section_state_next = SEC_DATA;
            end else if (word[TEXT_W-1:0] != '0) begin
              section_state_next = SEC_TEXT;
            end else if (last_group) begin
              section_state_next = SEC_TRAIL;
            end else begin
              group_current_next    = group_inc[7:0];
              section_state_next    = SEC_KEY;
              field_byte_count_next = '0;
            end
          end
        end else begin
          field_byte_count_next = field_byte_count + FCOUNT_W'(1);
        end
      end
      SEC_DATA: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == '0) begin
          if (text_left != '0) begin
            section_state_next = SEC_TEXT;
          end else if (last_group) begin
            section_state_next = SEC_TRAIL;
          end else begin
            group_current_next    = group_inc[7:0];
            section_state_next    = SEC_KEY;
            field_byte_count_next = '0;
          end
        end
      end
      SEC_TEXT: begin
        text_left_next = text_dec;
        if (text_dec == '0) begin
          if (last_group) begin
            section_state_next = SEC_TRAIL;
          end else begin
            group_current_next    = group_inc[7:0];
            section_state_next    = SEC_KEY;
            field_byte_count_next = '0;
          end
        end
      end
      default: begin
        // Trailing bytes, and every byte after an error.
        out_sec = SEC_TRAIL;
        if (error_code == ST_PARSING) begin
          error_code_next = ST_TRAILING;
        end
      end
    endcase

    // Status after this byte.
    if (error_code_next != ST_PARSING) begin
      status = error_code_next;
    end else if (final_byte) begin
      if (section_state_next == SEC_TRAIL) begin
        status = ST_ACCEPTED;
      end else if (section_state_next == SEC_HEADER) begin
        status = ST_SHORT_HEADER;
      end else begin
        status = ST_TRUNCATED;
      end
    end else begin
      status = ST_PARSING;
    end

    res.byte_value  = data_byte;
    res.section     = out_sec;
    res.group_index = group_current_next;
    res.status      = status;
    res.blob_done   = (error_code_next != ST_PARSING) || final_byte;
  end

  // State registers; the last byte of a blob returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst || (step && final_byte)) begin
      section_state    <= SEC_HEADER;
      field_byte_count <= '0;
      field_shift      <= '0;
      magic_ok         <= 1'b1;
      size_ok          <= 1'b0;
      count_ok         <= 1'b0;
      cnt_plausible    <= 1'b1;
      group_total      <= '0;
      group_current    <= '0;
      record_count     <= '0;
      text_left        <= '0;
      bytes_left       <= '0;
      error_code       <= ST_PARSING;
    end else if (step) begin
      section_state    <= section_state_next;
      field_byte_count <= field_byte_count_next;
      field_shift      <= field_shift_next;
      magic_ok         <= magic_ok_next;
      size_ok          <= size_ok_next;
      count_ok         <= count_ok_next;
      cnt_plausible    <= cnt_plausible_next;
      group_total      <= group_total_next;
      group_current    <= group_current_next;
      record_count     <= record_count_next;
      text_left        <= text_left_next;
      bytes_left       <= bytes_left_next;
      error_code       <= error_code_next;
    end
  end

endmodule

`default_nettype wire

/* src/packed_record_blob_validator_core.sv */
// Top level of the packed record blob validator: input register, parser, result register.
//
//   channel  | dir | payload                                          | handshake
//   ---------+-----+--------------------------------------------------+-----------
//   blob     | in  | data_byte, final_byte                            | valid/ready
//   result   | out | byte_value, section, group_index, status, done   | valid/ready
//   cfg      | in  | index, data                                      | valid/ready
//
// One byte enters per cycle while the result side does not stall; each result passes through
// the input register, then the parse step into the result register.
// The parse state loop closes in a single combinational step, which sets the one-byte-per-cycle rate.
// Reset is synchronous; it restores the registers to their defaults and the parse state.
// A stall on the result side holds both stages; the input takes a new beat whenever
// its register is empty or moves on. Configuration writes are always ready.
`default_nettype none

module packed_record_blob_validator_core (
  input wire logic  clk,
  input wire logic  rst,
  prbv_in_if.sink   blob,
  prbv_out_if.source result,
  prbv_cfg_if.sink  cfg
);
  import prbv_pkg::*;

  cfg_regs_t  regs;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_final;
  logic       out_valid;
  res_t       out_res;
  res_t       step_res;
  logic       advance;
  logic       step;

  // Stage control.
  assign advance    = !out_valid || result.ready;
  assign step       = in_valid && advance;
  assign blob.ready = !in_valid || advance;
  assign cfg.ready  = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_version <= RST_EXPECTED_VERSION;
      regs.record_size      <= RST_RECORD_SIZE;
      regs.max_groups       <= RST_MAX_GROUPS;
      regs.max_records      <= RST_MAX_RECORDS;
      regs.max_text_bytes   <= RST_MAX_TEXT_BYTES;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_EXPECTED_VERSION: regs.expected_version <= cfg.data;
        REG_RECORD_SIZE:      regs.record_size      <= cfg.data[RECSIZE_W-1:0];
        REG_MAX_GROUPS:       regs.max_groups       <= cfg.data[GROUPS_W-1:0];
        REG_MAX_RECORDS:      regs.max_records      <= cfg.data[RECORDS_W-1:0];
        REG_MAX_TEXT_BYTES:   regs.max_text_bytes   <= cfg.data[TEXT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (blob.ready) begin
      in_valid <= blob.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (blob.valid && blob.ready) begin
      in_byte  <= blob.data_byte;
      in_final <= blob.final_byte;
    end
  end

  prbv_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (in_byte),
    .final_byte (in_final),
    .regs       (regs),
    .res        (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= step_res;
    end
  end

  assign result.valid       = out_valid;
  assign result.byte_value  = out_res.byte_value;
  assign result.section     = out_res.section;
  assign result.group_index = out_res.group_index;
  assign result.status      = out_res.status;
  assign result.blob_done   = out_res.blob_done;

endmodule

`default_nettype wire
